// ----- rtl/atrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atrs_pkg
// Types and constants shared by the antenna tuner relay search sequencer.
// ----------------------------------------------------------------------------
package atrs_pkg;

    localparam int CODE_BITS = 7;
    localparam int SWR_BITS  = 10;
    localparam int VAR_BITS  = 14;

    localparam logic [CODE_BITS-1:0] CODE_MAX  = {CODE_BITS{1'b1}};
    localparam logic [CODE_BITS:0]   SWEEP_END = (CODE_BITS+1)'(1) << (CODE_BITS - 1);
    localparam logic [SWR_BITS-1:0]  SWR_TOP   = SWR_BITS'(999);
    localparam logic [VAR_BITS-1:0]  VAR_NONE  = VAR_BITS'(10000);
    localparam logic [SWR_BITS-1:0]  THR_RESET = SWR_BITS'(120);

    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_READING = 2'd1;
    localparam logic [1:0] CMD_RESET   = 2'd2;

    localparam logic [1:0] ST_MATCHED = 2'd0;
    localparam logic [1:0] ST_BEST    = 2'd1;
    localparam logic [1:0] ST_OFFSCL  = 2'd2;

    typedef enum logic [4:0] {
        P_IDLE, P_TU0, P_TU1, P_TU2, P_TU3, P_TU4, P_SU1, P_SU2,
        P_CT1, P_CT2, P_CT3, P_SW0, P_SW1, P_SH1, P_SH2, P_SH3, P_SH4
    } t_phase;

    typedef struct packed {
        logic [CODE_BITS-1:0]           ind;
        logic [CODE_BITS-1:0]           cap;
        logic                           side;
        t_phase                         phase;
        logic [CODE_BITS-1:0]           step;
        logic [SWR_BITS-1:0]            best_swr;
        logic [CODE_BITS-1:0]           best_code;
        logic [2:0][VAR_BITS-1:0]       var_swr;
        logic [2:0][CODE_BITS-1:0]      var_ind;
        logic [2:0][CODE_BITS-1:0]      var_cap;
        logic [SWR_BITS-1:0]            side_swr;
        logic [2*CODE_BITS-1:0]         side_codes;
        logic [1:0]                     sweep_kind;
        logic [2:0]                     coarse_stage;
        logic                           sharp_target;
        logic                           sharp_second;
        logic                           cap_first;
        logic [1:0]                     tune_pass;
    } t_state;

    typedef struct packed {
        t_state      st;
        logic        want;
        logic        done;
        logic [1:0]  status;
    } t_work;

    localparam t_state ST_INIT = '{
        ind: '0, cap: CODE_BITS'(1), side: 1'b0, phase: P_IDLE, step: CODE_BITS'(1),
        best_swr: '0, best_code: '0, var_swr: {3{VAR_NONE}}, var_ind: '0, var_cap: '0,
        side_swr: '0, side_codes: '0, sweep_kind: '0, coarse_stage: '0,
        sharp_target: 1'b0, sharp_second: 1'b0, cap_first: 1'b0, tune_pass: '0
    };

endpackage
`default_nettype wire

// ----- rtl/atrs_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atrs_req_if
// Command request channel: command code and SWR reading.
// ----------------------------------------------------------------------------
interface atrs_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [atrs_pkg::SWR_BITS-1:0] swr_reading;
    modport source (output valid, output cmd, output swr_reading, input ready);
    modport sink   (input valid, input cmd, input swr_reading, output ready);
endinterface
`default_nettype wire

// ----- rtl/atrs_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atrs_rsp_if
// Result channel: relay setting and tune status.
// ----------------------------------------------------------------------------
interface atrs_rsp_if;
    logic       valid;
    logic       ready;
    logic [atrs_pkg::CODE_BITS-1:0] inductor_code;
    logic [atrs_pkg::CODE_BITS-1:0] capacitor_code;
    logic       switch_side;
    logic       measure_request;
    logic       tune_done;
    logic [1:0] tune_status;
    modport source (output valid, output inductor_code, output capacitor_code,
                    output switch_side, output measure_request, output tune_done,
                    output tune_status, input ready);
    modport sink   (input valid, input inductor_code, input capacitor_code,
                    input switch_side, input measure_request, input tune_done,
                    input tune_status, output ready);
endinterface
`default_nettype wire

// ----- rtl/atrs_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atrs_cfg_if
// Configuration write channel for the good SWR threshold.
// ----------------------------------------------------------------------------
interface atrs_cfg_if;
    logic       valid;
    logic       ready;
    logic [atrs_pkg::SWR_BITS-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/atrs_next.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atrs_next
// Next-state logic: one sequencer transition per request.
// ----------------------------------------------------------------------------
module atrs_next (
    input  var atrs_pkg::t_state              i_st,
    input  var logic [1:0]                    i_cmd,
    input  var logic [atrs_pkg::SWR_BITS-1:0] i_swr,
    input  var logic [atrs_pkg::SWR_BITS-1:0] i_thr,
    output atrs_pkg::t_work                   o_work,
    output logic                              o_emit
);
    localparam int CB = atrs_pkg::CODE_BITS;
    localparam int SB = atrs_pkg::SWR_BITS;

    function automatic atrs_pkg::t_work f_measure(atrs_pkg::t_work w, atrs_pkg::t_phase p);
        w.st.phase = p;
        w.want = 1'b1;
        return w;
    endfunction

    function automatic atrs_pkg::t_work f_finish(atrs_pkg::t_work w, logic [1:0] s);
        w.st.phase = atrs_pkg::P_IDLE;
        w.done = 1'b1;
        w.status = s;
        return w;
    endfunction

    // x / 10 by reciprocal, exact for the code range, floored at 1
    function automatic logic [CB-1:0] f_fine(logic [CB-1:0] x);
        logic [CB+8:0] m;
        logic [CB-1:0] q;
        m = (CB+9)'(x) * (CB+9)'(205);
        q = CB'(m >> 11);
        return (q == '0) ? CB'(1) : q;
    endfunction

    function automatic logic [CB-1:0] f_tgt(atrs_pkg::t_work w);
        return w.st.sharp_target ? w.st.ind : w.st.cap;
    endfunction

    function automatic atrs_pkg::t_work f_set_tgt(atrs_pkg::t_work w, logic [CB-1:0] v);
        if (w.st.sharp_target) begin
            w.st.ind = v;
        end else begin
            w.st.cap = v;
        end
        return w;
    endfunction

    function automatic atrs_pkg::t_work f_start_sharp(atrs_pkg::t_work w, logic t);
        w.st.sharp_target = t;
        w.st.best_code = f_tgt(w);
        w.st.step = f_fine(f_tgt(w));
        return f_measure(w, atrs_pkg::P_SH1);
    endfunction

    function automatic atrs_pkg::t_work f_start_sharp_tune(atrs_pkg::t_work w);
        w.st.cap_first = (w.st.cap >= w.st.ind);
        w.st.sharp_second = 1'b0;
        return f_start_sharp(w, !w.st.cap_first);
    endfunction

    function automatic atrs_pkg::t_work f_sub_return(atrs_pkg::t_work w);
        return f_measure(w, (w.st.tune_pass == 2'd0) ? atrs_pkg::P_TU1 : atrs_pkg::P_TU2);
    endfunction

    function automatic atrs_pkg::t_work f_sharp_done(atrs_pkg::t_work w);
        w = f_set_tgt(w, w.st.best_code);
        if (!w.st.sharp_second) begin
            w.st.sharp_second = 1'b1;
            w = f_start_sharp(w, w.st.cap_first);
        end else if (w.st.tune_pass == 2'd2) begin
            w = f_measure(w, atrs_pkg::P_TU4);
        end else begin
            w = f_sub_return(w);
        end
        return w;
    endfunction

    function automatic atrs_pkg::t_work f_start_sweep(atrs_pkg::t_work w, logic [1:0] k);
        w.st.sweep_kind = k;
        return f_measure(w, atrs_pkg::P_SW0);
    endfunction

    function automatic atrs_pkg::t_work f_sweep_apply(atrs_pkg::t_work w, logic [CB-1:0] c);
        if (w.st.sweep_kind == 2'd0) begin
            w.st.cap = c;
        end else if (w.st.sweep_kind == 2'd1) begin
            w.st.ind = c;
        end else begin
            w.st.ind = c;
            w.st.cap = c;
        end
        return w;
    endfunction

    function automatic atrs_pkg::t_work f_sweep_done(atrs_pkg::t_work w);
        case (w.st.coarse_stage)
            3'd0: begin
                w.st.coarse_stage = 3'd1;
                w = f_start_sweep(w, 2'd1);
            end
            3'd1: w = f_measure(w, atrs_pkg::P_CT1);
            3'd2: begin
                w.st.coarse_stage = 3'd3;
                w = f_start_sweep(w, 2'd0);
            end
            3'd3: w = f_measure(w, atrs_pkg::P_CT2);
            default: w = f_measure(w, atrs_pkg::P_CT3);
        endcase
        return w;
    endfunction

    function automatic atrs_pkg::t_work f_start_coarse(atrs_pkg::t_work w);
        w.st.var_swr = {3{atrs_pkg::VAR_NONE}};
        w.st.coarse_stage = 3'd0;
        return f_start_sweep(w, 2'd0);
    endfunction

    function automatic atrs_pkg::t_work f_keep(atrs_pkg::t_work w, logic [1:0] v,
                                               logic [SB-1:0] r);
        w.st.var_swr[v] = atrs_pkg::VAR_BITS'(r);
        w.st.var_ind[v] = w.st.ind;
        w.st.var_cap[v] = w.st.cap;
        return w;
    endfunction

    function automatic atrs_pkg::t_work f_pick(atrs_pkg::t_work w);
        logic [atrs_pkg::VAR_BITS-1:0] a, b, c;
        logic [1:0] v;
        a = w.st.var_swr[0];
        b = w.st.var_swr[1];
        c = w.st.var_swr[2];
        if (a <= b && a <= c) begin
            v = 2'd0;
        end else if (b <= a && b <= c) begin
            v = 2'd1;
        end else begin
            v = 2'd2;
        end
        w.st.ind = w.st.var_ind[v];
        w.st.cap = w.st.var_cap[v];
        return f_measure(w, atrs_pkg::P_SU2);
    endfunction

    function automatic atrs_pkg::t_work f_try3(atrs_pkg::t_work w);
        if (w.st.cap <= CB'(2) && w.st.ind <= CB'(2)) begin
            w.st.cap = '0;
            w.st.ind = '0;
            w.st.coarse_stage = 3'd4;
            w = f_start_sweep(w, 2'd2);
        end else begin
            w = f_pick(w);
        end
        return w;
    endfunction

    function automatic atrs_pkg::t_work f_try2(atrs_pkg::t_work w);
        if (w.st.cap <= CB'(2) && w.st.ind <= CB'(2)) begin
            w.st.cap = '0;
            w.st.ind = '0;
            w.st.coarse_stage = 3'd2;
            w = f_start_sweep(w, 2'd1);
        end else begin
            w = f_try3(w);
        end
        return w;
    endfunction

    function automatic atrs_pkg::t_work f_start_sub(atrs_pkg::t_work w);
        w.st.cap = '0;
        w.st.ind = '0;
        return f_measure(w, atrs_pkg::P_SU1);
    endfunction

    function automatic atrs_pkg::t_work f_tail(atrs_pkg::t_work w, logic ok);
        if (ok) begin
            w = f_finish(w, atrs_pkg::ST_MATCHED);
        end else begin
            w.st.tune_pass = 2'd2;
            w = f_start_sharp_tune(w);
        end
        return w;
    endfunction

    logic [SB-1:0]   s_r;
    logic [SB+7:0]   s_r_mul;
    logic [SB-1:0]   s_r10;
    logic            s_ok;
    logic [CB:0]     s_x;
    logic [CB:0]     s_x2;
    logic [CB-1:0]   s_stp;
    logic [CB-1:0]   s_cur;
    atrs_pkg::t_work w;

    assign s_r     = (i_swr > atrs_pkg::SWR_TOP) ? atrs_pkg::SWR_TOP : i_swr;
    assign s_r_mul = (SB+8)'(s_r) * (SB+8)'(205);
    assign s_r10   = SB'(s_r_mul >> 11);
    assign s_ok    = (s_r <= i_thr);

    always_comb begin
        w = '{st: i_st, want: 1'b0, done: 1'b0, status: 2'd0};
        o_emit = 1'b1;
        s_x = '0;
        s_x2 = '0;
        s_stp = '0;
        s_cur = '0;
        case (i_cmd)
            atrs_pkg::CMD_START: begin
                w.st.tune_pass = 2'd0;
                w = f_measure(w, atrs_pkg::P_TU0);
            end
            atrs_pkg::CMD_RESET: begin
                w.st.ind = '0;
                w.st.cap = CB'(1);
                w.st.side = 1'b0;
                w.st.phase = atrs_pkg::P_IDLE;
            end
            atrs_pkg::CMD_READING: begin
                if (i_st.phase == atrs_pkg::P_IDLE) begin
                    o_emit = 1'b0;
                end
                s_x = {1'b0, f_tgt(w)};
                unique case (i_st.phase)
                    atrs_pkg::P_TU0: begin
                        if (s_ok) begin
                            w = f_finish(w, atrs_pkg::ST_MATCHED);
                        end else begin
                            w.st.tune_pass = 2'd0;
                            w = f_start_sub(w);
                        end
                    end
                    atrs_pkg::P_TU1: begin
                        if (s_ok) begin
                            w = f_finish(w, atrs_pkg::ST_MATCHED);
                        end else begin
                            w.st.side_swr = s_r;
                            w.st.side_codes = {w.st.ind, w.st.cap};
                            w.st.side = !w.st.side;
                            w.st.tune_pass = 2'd1;
                            w = f_start_sub(w);
                        end
                    end
                    atrs_pkg::P_TU2: begin
                        if (s_r > w.st.side_swr) begin
                            w.st.side = !w.st.side;
                            w.st.ind = w.st.side_codes[2*CB-1:CB];
                            w.st.cap = w.st.side_codes[CB-1:0];
                            w = f_measure(w, atrs_pkg::P_TU3);
                        end else begin
                            w = f_tail(w, s_ok);
                        end
                    end
                    atrs_pkg::P_TU3: w = f_tail(w, s_ok);
                    atrs_pkg::P_TU4: begin
                        if (s_r == atrs_pkg::SWR_TOP) begin
                            w.st.ind = '0;
                            w.st.cap = CB'(1);
                            w.st.side = 1'b0;
                            w = f_finish(w, atrs_pkg::ST_OFFSCL);
                        end else begin
                            w = f_finish(w, atrs_pkg::ST_BEST);
                        end
                    end
                    atrs_pkg::P_SU1: w = s_ok ? f_sub_return(w) : f_start_coarse(w);
                    atrs_pkg::P_SU2: w = s_ok ? f_sub_return(w) : f_start_sharp_tune(w);
                    atrs_pkg::P_CT1: begin
                        if (s_ok) begin
                            w = f_measure(w, atrs_pkg::P_SU2);
                        end else begin
                            w = f_try2(f_keep(w, 2'd0, s_r));
                        end
                    end
                    atrs_pkg::P_CT2: begin
                        if (s_ok) begin
                            w = f_measure(w, atrs_pkg::P_SU2);
                        end else begin
                            w = f_try3(f_keep(w, 2'd1, s_r));
                        end
                    end
                    atrs_pkg::P_CT3: begin
                        if (s_ok) begin
                            w = f_measure(w, atrs_pkg::P_SU2);
                        end else begin
                            w = f_pick(f_keep(w, 2'd2, s_r));
                        end
                    end
                    atrs_pkg::P_SW0: begin
                        w.st.best_swr = s_r10;
                        w.st.best_code = '0;
                        w = f_measure(f_sweep_apply(w, CB'(1)), atrs_pkg::P_SW1);
                    end
                    atrs_pkg::P_SW1: begin
                        s_cur = (w.st.sweep_kind == 2'd0) ? w.st.cap : w.st.ind;
                        if (s_r10 <= w.st.best_swr) begin
                            w.st.best_code = s_cur;
                            w.st.best_swr = s_r10;
                        end
                        if (s_r10 <= i_st.best_swr && {s_cur, 1'b0} < atrs_pkg::SWEEP_END) begin
                            w = f_measure(f_sweep_apply(w, CB'({s_cur, 1'b0})),
                                          atrs_pkg::P_SW1);
                        end else begin
                            w = f_sweep_done(f_sweep_apply(w, w.st.best_code));
                        end
                    end
                    atrs_pkg::P_SH1: begin
                        w.st.best_swr = s_r;
                        s_x2 = s_x + {1'b0, w.st.step};
                        if (s_x2 > {1'b0, atrs_pkg::CODE_MAX}) begin
                            s_x2 = {1'b0, atrs_pkg::CODE_MAX};
                        end
                        w = f_measure(f_set_tgt(w, s_x2[CB-1:0]), atrs_pkg::P_SH2);
                    end
                    atrs_pkg::P_SH2: begin
                        s_stp = w.st.step;
                        if (s_r <= w.st.best_swr) begin
                            w.st.best_swr = s_r;
                            w.st.best_code = s_x[CB-1:0];
                            s_x2 = s_x + {1'b0, s_stp};
                            w = f_set_tgt(w, s_x2[CB-1:0]);
                            if (s_x2 <= {1'b0, atrs_pkg::CODE_MAX - s_stp}) begin
                                w = f_measure(w, atrs_pkg::P_SH3);
                            end else begin
                                w = f_sharp_done(w);
                            end
                        end else begin
                            w.st.best_swr = s_r;
                            s_x2 = (s_x >= {1'b0, s_stp}) ? s_x - {1'b0, s_stp} : s_x;
                            w = f_set_tgt(w, s_x2[CB-1:0]);
                            if (s_x2 >= {1'b0, s_stp}) begin
                                w = f_measure(w, atrs_pkg::P_SH4);
                            end else begin
                                w = f_sharp_done(w);
                            end
                        end
                    end
                    atrs_pkg::P_SH3: begin
                        if (s_r <= w.st.best_swr) begin
                            w.st.best_code = s_x[CB-1:0];
                            w.st.best_swr = s_r;
                            s_stp = f_fine(s_x[CB-1:0]);
                            w.st.step = s_stp;
                            s_x2 = s_x + {1'b0, s_stp};
                            w = f_set_tgt(w, s_x2[CB-1:0]);
                            if (s_x2 <= {1'b0, atrs_pkg::CODE_MAX - s_stp}) begin
                                w = f_measure(w, atrs_pkg::P_SH3);
                            end else begin
                                w = f_sharp_done(w);
                            end
                        end else begin
                            w = f_sharp_done(w);
                        end
                    end
                    atrs_pkg::P_SH4: begin
                        if (s_r <= w.st.best_swr) begin
                            w.st.best_code = s_x[CB-1:0];
                            w.st.best_swr = s_r;
                            s_stp = f_fine(s_x[CB-1:0]);
                            w.st.step = s_stp;
                            if (s_x >= {1'b0, s_stp}) begin
                                s_x2 = s_x - {1'b0, s_stp};
                                w = f_set_tgt(w, s_x2[CB-1:0]);
                                if (s_x2 >= {1'b0, s_stp}) begin
                                    w = f_measure(w, atrs_pkg::P_SH4);
                                end else begin
                                    w = f_sharp_done(w);
                                end
                            end else begin
                                w = f_sharp_done(w);
                            end
                        end else begin
                            w = f_sharp_done(w);
                        end
                    end
                    default: w.st.phase = atrs_pkg::P_IDLE;
                endcase
            end
            default: o_emit = 1'b0;
        endcase
        o_work = w;
    end

endmodule
`default_nettype wire

// ----- rtl/antenna_tuner_relay_search.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// antenna_tuner_relay_search
// Automatic antenna tuner search sequencer: one state step per request.
//
//   channel  dir  carries
//   i_req    in   cmd, swr_reading
//   o_rsp    out  relay codes, switch side, measure/done flags, status
//   i_cfg    in   good SWR threshold
//
// A request passes the input register, then one step of the sequencer
// logic into the result register. One request per cycle sustained unless the result stalls.
// Synchronous active-low reset; state to ind 0, cap 1, side 0, threshold 120.
// Result back-pressure stalls the input register, then i_req.ready.
// ----------------------------------------------------------------------------
module antenna_tuner_relay_search (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    atrs_req_if.sink     i_req,
    atrs_cfg_if.sink     i_cfg,
    atrs_rsp_if.source   o_rsp
);
    logic                              r_in_valid;
    logic [1:0]                        r_in_cmd;
    logic [atrs_pkg::SWR_BITS-1:0]     r_in_swr;
    logic [atrs_pkg::SWR_BITS-1:0]     r_thr;
    atrs_pkg::t_state                  r_st;
    logic                              r_out_valid;
    atrs_pkg::t_work                   r_out;
    atrs_pkg::t_work                   n_work;
    logic                              s_emit;
    logic                              s_adv;

    assign s_adv       = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || s_adv;
    assign i_cfg.ready = 1'b1;

    atrs_next u_next (
        .i_st   (r_st),
        .i_cmd  (r_in_cmd),
        .i_swr  (r_in_swr),
        .i_thr  (r_thr),
        .o_work (n_work),
        .o_emit (s_emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_thr       <= atrs_pkg::THR_RESET;
            r_st        <= atrs_pkg::ST_INIT;
        end else begin
            if (i_cfg.valid) begin
                r_thr <= i_cfg.data;
            end
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (s_adv) begin
                r_in_valid <= 1'b0;
            end
            if (s_adv) begin
                r_st        <= n_work.st;
                r_out_valid <= s_emit;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_cmd <= i_req.cmd;
            r_in_swr <= i_req.swr_reading;
        end
        if (s_adv) begin
            r_out <= n_work;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.inductor_code   = r_out.st.ind;
    assign o_rsp.capacitor_code  = r_out.st.cap;
    assign o_rsp.switch_side     = r_out.st.side;
    assign o_rsp.measure_request = r_out.want;
    assign o_rsp.tune_done       = r_out.done;
    assign o_rsp.tune_status     = r_out.status;

endmodule
`default_nettype wire
